[sv/tsn_pkg.sv]
package tsn_pkg;

   // Texel store geometry
   localparam int TEXEL_DEPTH = 65536;
   localparam int MEM_AW      = $clog2(TEXEL_DEPTH);

   // Checker square size is 2^-CHECK_SCALE_LOG2 in texture space
   localparam int CHECK_SCALE_LOG2 = 4;
   localparam int CHECK_BIT        = 16 - CHECK_SCALE_LOG2;

   // Field widths
   localparam int COORD_W = 24;
   localparam int FRAC_W  = 16;
   localparam int SIZE_W  = 9;
   localparam int ADDR_W  = 16;
   localparam int RGB_W   = 24;
   localparam int CHAN_W  = 8;
   localparam int IDX_W   = 2 * SIZE_W + 1;

   // Result queue
   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

   // Register port
   localparam int CSR_AW = 5;
   localparam int CSR_DW = 32;

   typedef enum logic [1:0] {
      MODE_SOLID   = 2'd0,
      MODE_CHECKER = 2'd1,
      MODE_IMAGE   = 2'd2,
      MODE_NONE    = 2'd3
   } tsn_mode_type;

   typedef enum logic [2:0] {
      REG_MODE    = 3'd0,
      REG_SOLID   = 3'd1,
      REG_CHECK_A = 3'd2,
      REG_CHECK_B = 3'd3,
      REG_OFF_U   = 3'd4,
      REG_OFF_V   = 3'd5,
      REG_WIDTH   = 3'd6,
      REG_HEIGHT  = 3'd7
   } tsn_reg_type;

   typedef struct packed {
      tsn_mode_type        mode;
      logic [RGB_W-1:0]    solid;
      logic [RGB_W-1:0]    check_a;
      logic [RGB_W-1:0]    check_b;
      logic [FRAC_W-1:0]   off_u;
      logic [FRAC_W-1:0]   off_v;
      logic [SIZE_W-1:0]   width;
      logic [SIZE_W-1:0]   height;
   } tsn_cfg_type;

   // Request payload carried down the pipe next to the index math
   typedef struct packed {
      logic                load;
      logic                image;
      logic [RGB_W-1:0]    colour;
      logic [ADDR_W-1:0]   waddr;
   } tsn_item_type;

endpackage

[sv/tsn_addr_gen.sv]
module tsn_addr_gen
   import tsn_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  tsn_cfg_type               cfg,
   input  logic                      take,
   input  logic                      req_action,
   input  logic signed [COORD_W-1:0] req_u_coord,
   input  logic signed [COORD_W-1:0] req_v_coord,
   input  logic [ADDR_W-1:0]         req_texel_address,
   input  logic [RGB_W-1:0]          req_texel_rgb,
   output logic                      out_vld,
   output tsn_item_type              out_item,
   output logic [IDX_W-1:0]          out_idx,
   output logic                      out_oob
);

   logic                  s1_vld_ff, s2_vld_ff, s3_vld_ff;
   tsn_item_type          s1_item_ff, s2_item_ff, s3_item_ff;
   tsn_item_type          s1_item_in;
   logic [FRAC_W-1:0]     fu_ff, fv_ff;
   logic [SIZE_W-1:0]     col_ff, row_ff;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic                  oob_ff;
   logic                  parity;
   logic [FRAC_W+SIZE_W-1:0] prod_u, prod_v;
   logic [2*SIZE_W-1:0]   row_base;

   // Pick the fixed colour for non-image modes, or the texel for a load
   assign parity = req_u_coord[CHECK_BIT] ^ req_v_coord[CHECK_BIT];

   always_comb begin
      s1_item_in.load  = req_action;
      s1_item_in.image = (cfg.mode == MODE_IMAGE);
      s1_item_in.waddr = req_texel_address;
      if (req_action) begin
         s1_item_in.colour = req_texel_rgb;
      end else begin
         unique case (cfg.mode)
            MODE_SOLID:   s1_item_in.colour = cfg.solid;
            MODE_CHECKER: s1_item_in.colour = parity ? cfg.check_b : cfg.check_a;
            default:      s1_item_in.colour = '0;
         endcase
      end
   end

   // Scale the wrapped fractions by the texture size
   assign prod_u = (FRAC_W+SIZE_W)'(fu_ff) * (FRAC_W+SIZE_W)'(cfg.width);
   assign prod_v = (FRAC_W+SIZE_W)'(fv_ff) * (FRAC_W+SIZE_W)'(cfg.height);

   // Linear index and store bound check
   assign row_base = (2*SIZE_W)'(row_ff) * (2*SIZE_W)'(cfg.width);
   assign idx_in   = IDX_W'(row_base) + IDX_W'(col_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= take;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
      end
      s1_item_ff <= s1_item_in;
      fu_ff      <= req_u_coord[FRAC_W-1:0] + cfg.off_u;
      fv_ff      <= req_v_coord[FRAC_W-1:0] + cfg.off_v;
      s2_item_ff <= s1_item_ff;
      col_ff     <= prod_u[FRAC_W+SIZE_W-1:FRAC_W];
      row_ff     <= prod_v[FRAC_W+SIZE_W-1:FRAC_W];
      s3_item_ff <= s2_item_ff;
      idx_ff     <= idx_in;
      oob_ff     <= (32'(idx_in) >= TEXEL_DEPTH);
   end

   assign out_vld  = s3_vld_ff;
   assign out_item = s3_item_ff;
   assign out_idx  = idx_ff;
   assign out_oob  = oob_ff;

endmodule

[sv/tsn_texel_ram.sv]
module tsn_texel_ram
   import tsn_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               in_vld,
   input  tsn_item_type       in_item,
   input  logic [IDX_W-1:0]   in_idx,
   input  logic               in_oob,
   output logic               push,
   output logic [RGB_W-1:0]   push_rgb
);

   logic [RGB_W-1:0]  mem [TEXEL_DEPTH];
   logic [RGB_W-1:0]  rd_data_ff;
   logic              s4_vld_ff;
   tsn_item_type      s4_item_ff;
   logic              s4_oob_ff;
   logic              wr_en;

   // Loads and samples hit the store at the same stage, so order is kept
   assign wr_en = in_vld && in_item.load && (32'(in_item.waddr) < TEXEL_DEPTH);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[MEM_AW'(in_item.waddr)] <= in_item.colour;
      end
      rd_data_ff <= mem[MEM_AW'(in_idx)];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else begin
         s4_vld_ff <= in_vld;
      end
      s4_item_ff <= in_item;
      s4_oob_ff  <= in_oob;
   end

   // Merge texel data with the fixed colour; out-of-store reads give black
   assign push = s4_vld_ff && !s4_item_ff.load;

   always_comb begin
      if (!s4_item_ff.image) begin
         push_rgb = s4_item_ff.colour;
      end else if (s4_oob_ff) begin
         push_rgb = '0;
      end else begin
         push_rgb = rd_data_ff;
      end
   end

endmodule

[sv/tsn_rsp_fifo.sv]
module tsn_rsp_fifo
   import tsn_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               take_sample,
   input  logic               push,
   input  logic [RGB_W-1:0]   push_rgb,
   output logic               full,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [RGB_W-1:0]   rsp_rgb
);

   logic [RGB_W-1:0]    q_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]  head_ff, tail_ff;
   logic [FIFO_CW-1:0]  count_ff, credit_ff;
   logic                pop;

   assign pop       = (count_ff != '0) && !rsp_stall;
   assign rsp_valid = (count_ff != '0);
   assign rsp_rgb   = q_ff[head_ff];

   // Stall requests once every queue slot is spoken for by an outstanding sample
   assign full = (credit_ff == FIFO_CW'(FIFO_DEPTH));

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[tail_ff] <= push_rgb;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff   <= '0;
         tail_ff   <= '0;
         count_ff  <= '0;
         credit_ff <= '0;
      end else begin
         if (push) begin
            tail_ff <= tail_ff + 1'b1;
         end
         if (pop) begin
            head_ff <= head_ff + 1'b1;
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
         case ({take_sample, pop})
            2'b10:   credit_ff <= credit_ff + 1'b1;
            2'b01:   credit_ff <= credit_ff - 1'b1;
            default: credit_ff <= credit_ff;
         endcase
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff != FIFO_CW'(FIFO_DEPTH)))
      else $error("result queue overflow");

   a_credit_covers: assert property (@(posedge clock) disable iff (reset)
      credit_ff >= count_ff)
      else $error("queued results exceed outstanding samples");

   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not advance on push");

endmodule

[sv/texture_sampler_nearest_unit.sv]
// Nearest-neighbour texture sampler. Each request either loads one 24-bit
// texel into the 64K-entry texel store (no response) or samples a colour at a
// signed Q8.16 (u,v) in solid, checkerboard, image or black mode, giving one
// RGB response. One request is taken per clock while req_stall is low; a
// sample's response passes three index stages and one store read, then the
// queue write presents it. Responses wait in an eight-entry queue, and
// req_stall rises only while eight samples are outstanding, so a consumer
// that never stalls sees full rate. The store has no reset: sample only
// texels that were loaded. Write the registers only while no request is in
// flight.
module texture_sampler_nearest_unit
   import tsn_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_action,
   input  logic signed [COORD_W-1:0] req_u_coord,
   input  logic signed [COORD_W-1:0] req_v_coord,
   input  logic [ADDR_W-1:0]         req_texel_address,
   input  logic [RGB_W-1:0]          req_texel_rgb,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [CHAN_W-1:0]         rsp_red,
   output logic [CHAN_W-1:0]         rsp_green,
   output logic [CHAN_W-1:0]         rsp_blue,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_AW-1:0]         csr_paddr,
   input  logic [CSR_DW-1:0]         csr_pwdata,
   output logic [CSR_DW-1:0]         csr_prdata,
   output logic                      csr_pready
);

   tsn_cfg_type        cfg_ff;
   tsn_reg_type        reg_sel;
   logic               csr_wr;
   logic               take;
   logic               ag_vld;
   tsn_item_type       ag_item;
   logic [IDX_W-1:0]   ag_idx;
   logic               ag_oob;
   logic               push;
   logic [RGB_W-1:0]   push_rgb;
   logic [RGB_W-1:0]   rsp_rgb;

   // Decode register writes
   assign csr_pready = 1'b1;
   assign reg_sel    = tsn_reg_type'(csr_paddr[CSR_AW-1:2]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode    <= MODE_NONE;
         cfg_ff.solid   <= '0;
         cfg_ff.check_a <= '0;
         cfg_ff.check_b <= '0;
         cfg_ff.off_u   <= '0;
         cfg_ff.off_v   <= '0;
         cfg_ff.width   <= SIZE_W'(1);
         cfg_ff.height  <= SIZE_W'(1);
      end else if (csr_wr) begin
         unique case (reg_sel)
            REG_MODE:    cfg_ff.mode    <= tsn_mode_type'(csr_pwdata[1:0]);
            REG_SOLID:   cfg_ff.solid   <= csr_pwdata[RGB_W-1:0];
            REG_CHECK_A: cfg_ff.check_a <= csr_pwdata[RGB_W-1:0];
            REG_CHECK_B: cfg_ff.check_b <= csr_pwdata[RGB_W-1:0];
            REG_OFF_U:   cfg_ff.off_u   <= csr_pwdata[FRAC_W-1:0];
            REG_OFF_V:   cfg_ff.off_v   <= csr_pwdata[FRAC_W-1:0];
            REG_WIDTH:   cfg_ff.width   <= csr_pwdata[SIZE_W-1:0];
            REG_HEIGHT:  cfg_ff.height  <= csr_pwdata[SIZE_W-1:0];
            default:     cfg_ff.mode    <= cfg_ff.mode;
         endcase
      end
   end

   // Return the selected register
   always_comb begin
      unique case (reg_sel)
         REG_MODE:    csr_prdata = CSR_DW'(cfg_ff.mode);
         REG_SOLID:   csr_prdata = CSR_DW'(cfg_ff.solid);
         REG_CHECK_A: csr_prdata = CSR_DW'(cfg_ff.check_a);
         REG_CHECK_B: csr_prdata = CSR_DW'(cfg_ff.check_b);
         REG_OFF_U:   csr_prdata = CSR_DW'(cfg_ff.off_u);
         REG_OFF_V:   csr_prdata = CSR_DW'(cfg_ff.off_v);
         REG_WIDTH:   csr_prdata = CSR_DW'(cfg_ff.width);
         REG_HEIGHT:  csr_prdata = CSR_DW'(cfg_ff.height);
         default:     csr_prdata = '0;
      endcase
   end

   assign take = req_valid && !req_stall;

   tsn_addr_gen u_addr_gen (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .take              (take),
      .req_action        (req_action),
      .req_u_coord       (req_u_coord),
      .req_v_coord       (req_v_coord),
      .req_texel_address (req_texel_address),
      .req_texel_rgb     (req_texel_rgb),
      .out_vld           (ag_vld),
      .out_item          (ag_item),
      .out_idx           (ag_idx),
      .out_oob           (ag_oob)
   );

   tsn_texel_ram u_texel_ram (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (ag_vld),
      .in_item  (ag_item),
      .in_idx   (ag_idx),
      .in_oob   (ag_oob),
      .push     (push),
      .push_rgb (push_rgb)
   );

   tsn_rsp_fifo u_rsp_fifo (
      .clock       (clock),
      .reset       (reset),
      .take_sample (take && !req_action),
      .push        (push),
      .push_rgb    (push_rgb),
      .full        (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_rgb     (rsp_rgb)
   );

   // Split the packed colour into channels
   assign rsp_red   = rsp_rgb[3*CHAN_W-1:2*CHAN_W];
   assign rsp_green = rsp_rgb[2*CHAN_W-1:CHAN_W];
   assign rsp_blue  = rsp_rgb[CHAN_W-1:0];

endmodule
